// File: rtl/core/opg_pkg.sv
// Package for the on-demand performance-state governor.
// Item types, per-CPU state record, register codes and ladder helpers.
// No dependencies.
`default_nettype none
package opg_pkg;

  localparam int MAX_CPUS   = 8;
  localparam int CPU_W      = $clog2(MAX_CPUS);
  localparam int MAX_STATES = 16;

  localparam logic [3:0] STATE_LAST = 4'(MAX_STATES - 1);

  // request codes
  localparam logic [1:0] REQ_TICK      = 2'd0;
  localparam logic [1:0] REQ_SET_GOV   = 2'd1;
  localparam logic [1:0] REQ_SET_STATE = 2'd2;

  // governor codes
  localparam logic [1:0] GOV_PERF   = 2'd0;
  localparam logic [1:0] GOV_SAVE   = 2'd1;
  localparam logic [1:0] GOV_DEMAND = 2'd2;
  localparam logic [1:0] GOV_SCHED  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_MAX_RATIO      = 3'd0;
  localparam logic [2:0] CFG_FLOOR_RATIO    = 3'd1;
  localparam logic [2:0] CFG_ACTIVE_CPUS    = 3'd2;
  localparam logic [2:0] CFG_UP_THRESHOLD   = 3'd3;
  localparam logic [2:0] CFG_DOWN_THRESHOLD = 3'd4;

  localparam logic [7:0] FALLBACK_MAX_RATIO   = 8'd20;
  localparam logic [7:0] FALLBACK_FLOOR_RATIO = 8'd8;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] cpu_index;
    logic       idle_tick;
    logic [1:0] new_governor;
    logic [7:0] new_state;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  state_index;
    logic [14:0] core_mhz;
    logic [11:0] supply_mv;
    logic        ctl_write_valid;
    logic [15:0] ctl_word;
    logic [6:0]  load_pct;
    logic [1:0]  governor_now;
  } out_item_t;

  typedef struct packed {
    logic [3:0] tick_count;
    logic [4:0] busy_count;
    logic [3:0] current_state;
    logic [1:0] governor_mode;
    logic [6:0] recent_load;
  } cpu_state_t;

  localparam cpu_state_t CPU_STATE_RESET = '{
    tick_count:    4'd0,
    busy_count:    5'd0,
    current_state: 4'd0,
    governor_mode: GOV_DEMAND,
    recent_load:   7'd0
  };

  typedef struct packed {
    logic [7:0] max_ratio;
    logic [7:0] floor_ratio;
    logic [3:0] active_cpus;
    logic [6:0] up_threshold;
    logic [6:0] down_threshold;
  } cfg_t;

  // ladder shrink event, raised in the cycle a ratio register is written
  typedef struct packed {
    logic       en;
    logic [3:0] last;
  } clamp_evt_t;

  // result before frequency/voltage scaling
  typedef struct packed {
    logic       rejected;
    logic       accepted;
    logic [3:0] state_index;
    logic [7:0] ratio;
    logic       ctl_wr;
    logic [6:0] load_pct;
    logic [1:0] governor_now;
  } res_t;

  function automatic logic [7:0] top_ratio(input logic [7:0] mx);
    return (mx == 8'd0) ? FALLBACK_MAX_RATIO : mx;
  endfunction

  // index of the slowest state of the ladder
  function automatic logic [3:0] ladder_last(input logic [7:0] mx, input logic [7:0] mn);
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] span;
    hi = top_ratio(mx);
    lo = (mn == 8'd0) ? FALLBACK_FLOOR_RATIO : mn;
    span = hi - lo;
    if (lo > hi) begin
      return 4'd0;
    end
    if (span >= {4'd0, STATE_LAST}) begin
      return STATE_LAST;
    end
    return span[3:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/opg_mem.sv
// Per-CPU state memory: one write port, one registered read port.
// Uses opg_pkg for the state record and depth.
`default_nettype none
module opg_mem (
  input  wire                       clk,
  input  wire                       rd_en,
  input  wire [opg_pkg::CPU_W-1:0]  rd_addr,
  output opg_pkg::cpu_state_t       rd_data,
  input  wire                       wr_en,
  input  wire [opg_pkg::CPU_W-1:0]  wr_addr,
  input  opg_pkg::cpu_state_t       wr_data
);
  import opg_pkg::*;

  cpu_state_t mem [MAX_CPUS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-before-write on a colliding address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/opg_cfg.sv
// Configuration registers of the governor and the ladder-shrink event.
// Uses opg_pkg for register codes and the ladder helper.
`default_nettype none
module opg_cfg (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 wr_en,
  input  wire [2:0]           wr_index,
  input  wire [7:0]           wr_data,
  output opg_pkg::cfg_t       cfg,
  output opg_pkg::clamp_evt_t clamp
);
  import opg_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    clamp   = '0;
    if (wr_en) begin
      case (wr_index)
        CFG_MAX_RATIO: begin
          cfg_nxt.max_ratio = wr_data;
          clamp.en = 1'b1;
        end
        CFG_FLOOR_RATIO: begin
          cfg_nxt.floor_ratio = wr_data;
          clamp.en = 1'b1;
        end
        CFG_ACTIVE_CPUS:    cfg_nxt.active_cpus    = wr_data[3:0];
        CFG_UP_THRESHOLD:   cfg_nxt.up_threshold   = wr_data[6:0];
        CFG_DOWN_THRESHOLD: cfg_nxt.down_threshold = wr_data[6:0];
        default: ;
      endcase
    end
    clamp.last = ladder_last(cfg_nxt.max_ratio, cfg_nxt.floor_ratio);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_ratio      <= 8'd20;
      cfg_r.floor_ratio    <= 8'd8;
      cfg_r.active_cpus    <= 4'd1;
      cfg_r.up_threshold   <= 7'd80;
      cfg_r.down_threshold <= 7'd20;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// File: rtl/core/opg_update.sv
// Next-state and result logic for one item against one CPU's state.
// Uses opg_pkg for types, codes and ladder helpers.
`default_nettype none
module opg_update (
  input  opg_pkg::in_item_t   item,
  input  wire                 rejected,
  input  opg_pkg::cpu_state_t st,
  input  opg_pkg::cfg_t       cfg,
  output opg_pkg::cpu_state_t st_nxt,
  output logic                wr_en,
  output opg_pkg::res_t       res
);
  import opg_pkg::*;

  logic [3:0]  last;
  logic [3:0]  tick1;
  logic [4:0]  busy1;
  logic [11:0] load_mul;
  logic [6:0]  load;
  logic        acc;
  logic        ctl_wr;

  assign last     = ladder_last(cfg.max_ratio, cfg.floor_ratio);
  assign tick1    = st.tick_count + 4'd1;
  assign busy1    = item.idle_tick ? st.busy_count : st.busy_count + 5'd1;
  // busy*100/16, kept to 7 bits
  assign load_mul = {7'd0, busy1} * 12'd100;
  assign load     = load_mul[10:4];

  always_comb begin
    st_nxt = st;
    acc    = 1'b0;
    ctl_wr = 1'b0;
    case (item.req_type)
      REQ_TICK: begin
        acc = 1'b1;
        st_nxt.tick_count = tick1;
        st_nxt.busy_count = busy1;
        if (tick1 == 4'd0) begin
          st_nxt.recent_load = load;
          st_nxt.busy_count  = 5'd0;
          if (st.governor_mode inside {GOV_DEMAND, GOV_SCHED}) begin
            if (load > cfg.up_threshold && st.current_state != 4'd0) begin
              st_nxt.current_state = st.current_state - 4'd1;
              ctl_wr = 1'b1;
            end else if (load < cfg.down_threshold && st.current_state < last) begin
              st_nxt.current_state = st.current_state + 4'd1;
              ctl_wr = 1'b1;
            end
          end
        end
      end
      REQ_SET_GOV: begin
        acc = 1'b1;
        st_nxt.governor_mode = item.new_governor;
        if (item.new_governor == GOV_PERF) begin
          st_nxt.current_state = 4'd0;
          ctl_wr = 1'b1;
        end else if (item.new_governor == GOV_SAVE) begin
          st_nxt.current_state = last;
          ctl_wr = 1'b1;
        end
      end
      REQ_SET_STATE: begin
        if (item.new_state <= {4'd0, last}) begin
          acc = 1'b1;
          ctl_wr = 1'b1;
          st_nxt.current_state = item.new_state[3:0];
        end
      end
      default: ;
    endcase
  end

  assign wr_en = acc && !rejected;

  always_comb begin
    res = '0;
    res.rejected     = rejected;
    if (!rejected) begin
      res.accepted     = acc;
      res.state_index  = st_nxt.current_state;
      res.ratio        = top_ratio(cfg.max_ratio) - {4'd0, st_nxt.current_state};
      res.ctl_wr       = ctl_wr;
      res.load_pct     = st_nxt.recent_load;
      res.governor_now = st_nxt.governor_mode;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ondemand_pstate_governor_core.sv
// Performance-state governor core: per-CPU state in a registered-read RAM, read-modify-write.
// Throughput: one item per cycle while the output register is free or out_ready is high; the
// state read lands in stage 1, and the result is registered in the output register for out_*.
// Reset: config registers to defaults, per-CPU valid bits cleared (unwritten CPUs read as
// reset state), shrink limits opened; no memory clearing pass, items accepted right away.
// Depends on opg_pkg, opg_mem, opg_cfg, opg_update.
`default_nettype none
module ondemand_pstate_governor_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  opg_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output opg_pkg::out_item_t  out_item,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [2:0]           cfg_index,
  input  wire [7:0]           cfg_data
);
  import opg_pkg::*;

  // configuration
  cfg_t       cfg;
  clamp_evt_t clamp;

  assign cfg_ready = 1'b1;

  opg_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .clamp    (clamp)
  );

  // stage 1: state read in flight / item being updated
  logic             s1_vld_r;
  in_item_t         s1_item_r;
  logic             s1_rej_r;
  logic             s1_adv;
  logic [CPU_W-1:0] s1_addr;
  logic [CPU_W-1:0] in_addr;
  logic             in_fire;
  logic             in_rej;
  logic [3:0]       cpu_limit;

  // output register
  logic out_vld_r;
  res_t out_res_r;

  assign s1_addr  = s1_item_r.cpu_index[CPU_W-1:0];
  assign in_addr  = in_item.cpu_index[CPU_W-1:0];
  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // CPUs at or beyond min(active_cpus, MAX_CPUS) are refused
  assign cpu_limit = (cfg.active_cpus > 4'(MAX_CPUS)) ? 4'(MAX_CPUS) : cfg.active_cpus;
  assign in_rej    = in_item.cpu_index >= {4'd0, cpu_limit};

  // state memory
  cpu_state_t rd_data;
  cpu_state_t st_nxt;
  logic       upd_wr;
  logic       mem_wr;

  assign mem_wr = s1_adv && upd_wr;

  opg_mem u_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (in_addr),
    .rd_data (rd_data),
    .wr_en   (mem_wr),
    .wr_addr (s1_addr),
    .wr_data (st_nxt)
  );

  // per-CPU valid bits and shrink limits (smallest last state seen since the entry was written)
  logic [MAX_CPUS-1:0] ent_vld_r;
  logic [3:0]          lim_r [MAX_CPUS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      for (int i = 0; i < MAX_CPUS; i++) begin
        lim_r[i] <= STATE_LAST;
      end
    end else begin
      for (int i = 0; i < MAX_CPUS; i++) begin
        if (mem_wr && s1_addr == CPU_W'(i)) begin
          ent_vld_r[i] <= 1'b1;
          lim_r[i]     <= STATE_LAST;
        end else if (clamp.en && clamp.last < lim_r[i]) begin
          lim_r[i] <= clamp.last;
        end
      end
    end
  end

  // forwarding: the item ahead writes the same CPU on the edge this read is issued
  logic       fwd_sel_r;
  cpu_state_t fwd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_sel_r <= 1'b0;
    end else if (in_fire) begin
      fwd_sel_r <= mem_wr && (in_addr == s1_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_data_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
      s1_rej_r  <= in_rej;
    end
  end

  // current state of the addressed CPU, with pending ladder shrink applied
  cpu_state_t st_cur;
  cpu_state_t st_base;

  always_comb begin
    if (fwd_sel_r) begin
      st_base = fwd_data_r;
    end else if (ent_vld_r[s1_addr]) begin
      st_base = rd_data;
    end else begin
      st_base = CPU_STATE_RESET;
    end
    st_cur = st_base;
    if (st_base.current_state > lim_r[s1_addr]) begin
      st_cur.current_state = lim_r[s1_addr];
    end
  end

  res_t upd_res;

  opg_update u_update (
    .item     (s1_item_r),
    .rejected (s1_rej_r),
    .st       (st_cur),
    .cfg      (cfg),
    .st_nxt   (st_nxt),
    .wr_en    (upd_wr),
    .res      (upd_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= upd_res;
    end
  end

  // scaling from the registered ratio; a refused CPU reports all zeros
  assign out_valid = out_vld_r;

  always_comb begin
    out_item = '0;
    if (!out_res_r.rejected) begin
      out_item.accepted        = out_res_r.accepted;
      out_item.state_index     = out_res_r.state_index;
      out_item.core_mhz        = {7'd0, out_res_r.ratio} * 15'd100;
      out_item.supply_mv       = 12'd800 + 12'd5 * {4'd0, out_res_r.ratio};
      out_item.ctl_write_valid = out_res_r.ctl_wr;
      out_item.ctl_word        = out_res_r.ctl_wr ? {out_res_r.ratio, 8'h00} : 16'h0000;
      out_item.load_pct        = out_res_r.load_pct;
      out_item.governor_now    = out_res_r.governor_now;
    end
  end

endmodule
`default_nettype wire
